// ===== hw/rtl/sha256_pkg.sv =====
// shared types, constants and round functions for the sha-256 hash core
// depends on nothing; used by every module of the core
`timescale 1ns / 1ps
package sha256_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [3:0] LEN_WORD = 4'd14;

    typedef struct packed {
        logic        msg_end;
        logic        blk_end;
        logic [31:0] word;
    } qword_t;

    typedef enum logic [2:0] {F_ACC, F_FIRST, F_ZERO, F_LHI, F_LLO} fstate_t;
    typedef enum logic [1:0] {B_IDLE, B_RND, B_ADD, B_OUT} bstate_t;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] v);
        big_s0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] v);
        big_s1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic logic [31:0] sm_s0(input logic [31:0] v);
        sm_s0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [31:0] sm_s1(input logic [31:0] v);
        sm_s1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

endpackage

// ===== hw/rtl/sha256_front.sv =====
// front end: takes message bytes, packs big-endian words, appends padding and length
// depends on sha256_pkg
`timescale 1ns / 1ps
module sha256_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tuser,
    input  logic                s_tlast,
    output logic                push,
    output sha256_pkg::qword_t  push_data,
    input  logic                full
);
    import sha256_pkg::*;

    fstate_t     state_reg, state_next;
    logic [60:0] cnt_reg, cnt_next;
    logic [31:0] wacc_reg, wacc_next;
    logic [3:0]  pi_reg, pi_next;
    logic [31:0] pad_word;

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'h0};
            2'd1:    pad_word = {wacc_reg[7:0], PAD_BYTE, 16'h0};
            2'd2:    pad_word = {wacc_reg[15:0], PAD_BYTE, 8'h0};
            default: pad_word = {wacc_reg[23:0], PAD_BYTE};
        endcase
    end

    assign s_tready = (state_reg == F_ACC) && !full;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        wacc_next  = wacc_reg;
        pi_next    = pi_reg;
        push       = 1'b0;
        push_data  = '{msg_end: 1'b0, blk_end: 1'b0, word: 32'h0};
        unique case (state_reg)
            F_ACC: begin
                if (s_tvalid && s_tready) begin
                    if (s_tuser) begin
                        wacc_next = {wacc_reg[23:0], s_tdata};
                        cnt_next  = cnt_reg + 61'd1;
                        if (cnt_reg[1:0] == 2'd3) begin
                            push              = 1'b1;
                            push_data.word    = {wacc_reg[23:0], s_tdata};
                            push_data.blk_end = (cnt_reg[5:0] == 6'd63);
                        end
                    end
                    if (s_tlast) begin
                        state_next = F_FIRST;
                    end
                end
            end
            F_FIRST: begin
                if (!full) begin
                    push              = 1'b1;
                    push_data.word    = pad_word;
                    push_data.blk_end = (cnt_reg[5:2] == 4'd15);
                    pi_next           = cnt_reg[5:2] + 4'd1;
                    state_next        = F_ZERO;
                end
            end
            F_ZERO: begin
                if (pi_reg == LEN_WORD) begin
                    state_next = F_LHI;
                end else if (!full) begin
                    push              = 1'b1;
                    push_data.blk_end = (pi_reg == 4'd15);
                    pi_next           = pi_reg + 4'd1;
                end
            end
            F_LHI: begin
                if (!full) begin
                    push           = 1'b1;
                    push_data.word = cnt_reg[60:29];
                    state_next     = F_LLO;
                end
            end
            F_LLO: begin
                if (!full) begin
                    push              = 1'b1;
                    push_data.word    = {cnt_reg[28:0], 3'b000};
                    push_data.blk_end = 1'b1;
                    push_data.msg_end = 1'b1;
                    cnt_next          = '0;
                    state_next        = F_ACC;
                end
            end
            default: state_next = F_ACC;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_ACC;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        wacc_reg <= wacc_next;
        pi_reg   <= pi_next;
    end

endmodule

// ===== hw/rtl/sha256_queue.sv =====
// short word queue between the front end and the compression engine
// depends on sha256_pkg
`timescale 1ns / 1ps
module sha256_queue #(
    parameter int DEPTH = sha256_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  sha256_pkg::qword_t  push_data,
    output logic                full,
    input  logic                pop,
    output sha256_pkg::qword_t  pop_data,
    output logic                empty
);
    import sha256_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qword_t         mem [DEPTH];
    logic [AW-1:0]  wr_reg, rd_reg;
    logic [CW-1:0]  cnt_reg;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
            end
            if (pop) begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

endmodule

// ===== hw/rtl/sha256_engine.sv =====
// back end: 64-round compression, chaining words and digest output register
// depends on sha256_pkg
`timescale 1ns / 1ps
module sha256_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                empty,
    input  sha256_pkg::qword_t  pop_data,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,
    output logic                m_tlast
);
    import sha256_pkg::*;

    bstate_t     state_reg, state_next;
    logic [5:0]  rnd_reg;
    logic [2:0]  idx_reg;
    logic        msg_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] wnew, t1, t2;
    logic        step;

    assign wnew = (rnd_reg < 6'd16) ? pop_data.word
                : sm_s1(w_reg[14]) + w_reg[9] + sm_s0(w_reg[1]) + w_reg[0];
    assign t1   = v_reg[7] + big_s1(v_reg[4])
                + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
                + ROUND_K[rnd_reg] + wnew;
    assign t2   = big_s0(v_reg[0])
                + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign step = (state_reg == B_RND) && ((rnd_reg >= 6'd16) || !empty);
    assign pop  = step && (rnd_reg < 6'd16);

    assign m_tvalid = (state_reg == B_OUT);
    assign m_tdata  = {5'b0, idx_reg, h_reg[idx_reg]};
    assign m_tlast  = (idx_reg == 3'd7);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (!empty) state_next = B_RND;
            B_RND:  if (step && rnd_reg == 6'd63) state_next = B_ADD;
            B_ADD:  state_next = msg_reg ? B_OUT : B_IDLE;
            B_OUT:  if (m_tready && idx_reg == 3'd7) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            msg_reg   <= 1'b0;
            h_reg     <= INIT_H;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_IDLE) begin
                rnd_reg <= '0;
                idx_reg <= '0;
            end
            if (step) begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd15) begin
                    msg_reg <= pop_data.msg_end;
                end
            end
            if (state_reg == B_ADD) begin
                for (int i = 0; i < 8; i++) begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
            if (m_tvalid && m_tready) begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == 3'd7) begin
                    h_reg <= INIT_H;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_IDLE) begin
            v_reg <= h_reg;
        end else if (step) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= wnew;
        end
    end

    a_pop_early: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (state_reg == B_RND) && (rnd_reg < 6'd16))
        else $error("queue popped outside the load rounds");
    a_out_after_add: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == B_ADD) && idx_reg == 3'd0)
        else $error("digest shown without a finished block");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(idx_reg))
        else $error("digest word dropped while stalled");

endmodule

// ===== hw/rtl/sha256_hash_core.sv =====
// top level of the sha-256 hash core: front end, word queue and compression engine
// depends on sha256_pkg, sha256_front, sha256_queue, sha256_engine
//
//  channel | dir | tdata (low bit up)                    | tuser      | tlast
//  s_      | in  | data_byte[7:0]                        | byte_valid | end_of_message
//  m_      | out | digest_word[31:0], word_index[34:32]  | -          | last_word
//
// one byte request per cycle while the front end is not padding a message tail and the queue has room
// each block takes one load of the working words, 64 rounds and one chaining add
// rounds 0 to 15 also wait whenever the queue is empty
// the message tail adds up to 18 padding words, then eight digest requests
// m_ stalls hold the digest; s_ keeps filling the queue until it is full
// aresetn is synchronous and clears counters, states and chaining words
`timescale 1ns / 1ps
module sha256_hash_core #(
    parameter int QUEUE_DEPTH = sha256_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // byte_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word, word_index, zero fill
    output logic        m_tlast
);
    import sha256_pkg::*;

    // words flowing from the padder to the round unit
    logic   push, full, pop, empty;
    qword_t push_data, pop_data;

    sha256_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
        .push, .push_data, .full
    );

    sha256_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk, .aresetn, .push, .push_data, .full, .pop, .pop_data, .empty
    );

    sha256_engine u_engine (
        .aclk, .aresetn, .empty, .pop_data, .pop,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast
    );

endmodule

// ===== sim/tb.sv =====
// self-checking bench for the sha-256 hash core: byte requests in, digest words out
// depends on sha256_hash_core and sha256_pkg; needs no files or arguments
`timescale 1ns / 1ps
module tb;
    import sha256_pkg::*;

    localparam int IDLE_MAX  = 12;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 200;
    localparam int ITEM_CNT  = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       eom;
    } byte_req_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    sha256_hash_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // model state of the hash: chaining words, block buffer, byte count
    logic [31:0] hash_h [8];
    logic [7:0]  blk_buf [64];
    logic [60:0] msg_len;

    byte_req_t   pending_bytes [$];
    digest_req_t digest_expect [$];
    int          fail_cnt = 0;
    bit          stim_done = 0;

    function automatic logic [31:0] ror(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // one 64-round compression of blk_buf into hash_h
    task automatic run_rounds();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int j = 0; j < 64; j++) begin
            if (j < 16)
                w[j] = {blk_buf[4*j], blk_buf[4*j+1], blk_buf[4*j+2], blk_buf[4*j+3]};
            else
                w[j] = (ror(w[j-2], 17) ^ ror(w[j-2], 19) ^ (w[j-2] >> 10)) + w[j-7]
                     + (ror(w[j-15], 7) ^ ror(w[j-15], 18) ^ (w[j-15] >> 3)) + w[j-16];
        end
        {a, b, c, d, e, f, g, h} = {hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                                    hash_h[4], hash_h[5], hash_h[6], hash_h[7]};
        for (int j = 0; j < 64; j++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_K[j] + w[j];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
        hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
    endtask

    // advance the model by one accepted byte request
    task automatic predict_hash(byte_req_t r);
        int unsigned p;
        logic [63:0] bits;
        if (r.valid) begin
            p = msg_len[5:0];
            blk_buf[p] = r.data;
            msg_len = msg_len + 1;
            if (p == 63) run_rounds();
        end
        if (r.eom) begin
            p = msg_len[5:0];
            blk_buf[p] = PAD_BYTE;
            p++;
            // length field no longer fits: close this block first
            if (p > 56) begin
                while (p < 64) blk_buf[p++] = '0;
                run_rounds();
                p = 0;
            end
            while (p < 56) blk_buf[p++] = '0;
            bits = {msg_len, 3'b000};
            for (int k = 0; k < 8; k++) blk_buf[56+k] = bits[63-8*k -: 8];
            run_rounds();
            for (int k = 0; k < 8; k++)
                digest_expect.push_back('{hash_h[k], 3'(k), k == 7});
            foreach (hash_h[k]) hash_h[k] = INIT_H[k];
            msg_len = '0;
        end
    endtask

    task automatic queue_msg(int n, bit empty_tail, bit fixed, logic [7:0] fv);
        for (int i = 0; i < n; i++)
            pending_bytes.push_back('{fixed ? fv : 8'($urandom), 1'b1,
                                     !empty_tail && i == n - 1});
        if (empty_tail || n == 0) pending_bytes.push_back('{8'($urandom), 1'b0, 1'b1});
    endtask

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // stimulus
    initial begin
        foreach (hash_h[k]) hash_h[k] = INIT_H[k];
        msg_len = '0;
        // directed: empty message, one byte, data extremes, an ignored request, short messages
        queue_msg(0, 1, 0, 0);
        queue_msg(1, 0, 1, 8'h00);
        queue_msg(1, 0, 1, 8'hff);
        pending_bytes.push_back('{8'h5a, 1'b0, 1'b0});   // ignored request
        queue_msg(2, 1, 1, 8'ha5);
        queue_msg(3, 0, 0, 0);
        // lengths around the length field and the block edge
        queue_msg(55, 0, 0, 0);
        queue_msg(56, 0, 0, 0);
        queue_msg(63, 1, 0, 0);
        queue_msg(64, 0, 0, 0);
        queue_msg(65, 0, 0, 0);
        // random messages, mostly short, mixed with ignored requests
        while (pending_bytes.size() < ITEM_CNT) begin
            int n;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 12);
            if (n > ITEM_CNT - pending_bytes.size()) n = ITEM_CNT - pending_bytes.size();
            if ($urandom_range(0, 3) == 0) pending_bytes.push_back('{8'($urandom), 1'b0, 1'b0});
            queue_msg(n, $urandom_range(0, 2) == 0, 0, 0);
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_bytes.size() == 0 && !s_tvalid);
        wait (digest_expect.size() == 0);
        repeat (DRAIN_CYC) @(posedge aclk);
        stim_done = 1;
    end

    // driver: one byte request at a time with random gaps
    int gap_in = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_hash('{s_tdata, s_tuser, s_tlast});
                gap_in = ($urandom_range(0, 3) == 0) ? $urandom_range(0, IDLE_MAX) : 0;
            end
            if ((!s_tvalid || s_tready) && gap_in == 0 && pending_bytes.size() > 0) begin
                byte_req_t r;
                r = pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= r.data;
                s_tuser  <= r.valid;
                s_tlast  <= r.eom;
            end else if (!s_tvalid || s_tready) begin
                s_tvalid <= 1'b0;
                if (gap_in > 0) gap_in--;
            end
        end
    end

    // monitor: random back-pressure and compare against the model
    int gap_out = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (digest_expect.size() == 0) begin
                    $display("%0t unexpected digest word: expected none, actual %h",
                             $time, m_tdata);
                    fail_cnt++;
                end else begin
                    digest_req_t x;
                    x = digest_expect.pop_front();
                    if (m_tdata[31:0] !== x.word || m_tdata[34:32] !== x.idx
                        || m_tlast !== x.last || m_tdata[39:35] !== 5'd0) begin
                        $display("%0t digest mismatch: expected %h idx %0d last %b, actual %h last %b",
                                 $time, x.word, x.idx, x.last, m_tdata, m_tlast);
                        fail_cnt++;
                    end
                end
                gap_out = ($urandom_range(0, 3) == 0) ? $urandom_range(0, IDLE_MAX) : 0;
            end
            if (gap_out > 0) begin
                gap_out--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any request moving
    int stall_cyc = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            stall_cyc = 0;
        else
            stall_cyc++;
    end

    initial begin
        wait (stim_done || stall_cyc >= WDOG_MAX);
        if (!stim_done) begin
            $display("status: fail");
        end else if (fail_cnt == 0 && digest_expect.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
